>>> hdl/mrc_pkg.sv
// ============================================================================
// mrc_pkg: shared types and constants of the mixed-radix index converter
// Field widths, the configuration register codes, the stage record that
// travels down the divider chain and the extent clamp.
// ============================================================================
package mrc_pkg;

    // Widths of the register and transaction fields.
    localparam int EXT_W     = 5;
    localparam int COMP_W    = 4;
    localparam int LIN_W     = 16;
    localparam int CAM_W     = 16;
    localparam int TOTAL_W   = 17;
    localparam int W1_W      = 2 * EXT_W;
    localparam int W2_W      = 3 * EXT_W;
    localparam int PROD_W    = 4 * EXT_W;

    // Three digits are split off by division; the top digit is the quotient.
    localparam int NUM_DIV   = 3;
    localparam int CHAIN_LEN = NUM_DIV * LIN_W;

    // Input register, chain cells, product stage and output register.
    localparam int PIPE_LAT  = CHAIN_LEN + 3;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUPER_SAMPLE = 2'd0,
        REG_SUB_SAMPLE   = 2'd1,
        REG_VIEWPORT     = 2'd2,
        REG_SUB_CAMERA   = 2'd3
    } cfg_reg_t;

    // Effective extents and the place weights derived from them.
    typedef struct packed {
        logic [EXT_W-1:0]   sub_sample;
        logic [EXT_W-1:0]   super_sample;
        logic [EXT_W-1:0]   viewport;
        logic [EXT_W-1:0]   sub_camera;
        logic [W1_W-1:0]    w1;
        logic [W2_W-1:0]    w2;
        logic [PROD_W-1:0]  total;
    } extents_t;

    // Record carried by every cell of the divider chain.
    typedef struct packed {
        logic                          mode;
        logic [LIN_W-1:0]              lin;
        logic [LIN_W-1:0]              quo;
        logic [EXT_W-1:0]              rem;
        logic [NUM_DIV-2:0][EXT_W-1:0] digit;
        logic [COMP_W-1:0]             super_sample;
        logic [COMP_W-1:0]             sub_sample;
        logic [COMP_W-1:0]             viewport;
        logic [COMP_W-1:0]             sub_camera;
    } stage_t;

    // A zero extent counts as one, and an extent above the cap is the cap.
    function automatic logic [EXT_W-1:0] eff_extent(
        input logic [EXT_W-1:0] v,
        input logic [EXT_W-1:0] cap
    );
        logic [EXT_W-1:0] r;
        if (v == '0)
        begin
            r = EXT_W'(1);
        end
        else if (v > cap)
        begin
            r = cap;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hdl/mrc_extents.sv
// ============================================================================
// mrc_extents: configuration registers and derived weights
// Holds the four extent registers, clamps them and builds the place weights
// and the total count through a short chain of registered multipliers.
// ============================================================================
module mrc_extents #(
    parameter int MAX_EXTENT = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrc_pkg::EXT_W-1:0]           cfg_data,
    output mrc_pkg::extents_t                   ext
);

    localparam int EW      = mrc_pkg::EXT_W;
    localparam int EXT_MAX = (1 << EW) - 1;
    localparam int CAP_INT = (MAX_EXTENT > EXT_MAX) ? EXT_MAX : MAX_EXTENT;
    localparam logic [EW-1:0] EXT_CAP = EW'(CAP_INT);

    logic [EW-1:0] super_sample_reg;
    logic [EW-1:0] sub_sample_reg;
    logic [EW-1:0] viewport_reg;
    logic [EW-1:0] sub_camera_reg;

    logic [mrc_pkg::W1_W-1:0]   w1_reg;
    logic [mrc_pkg::W2_W-1:0]   w2_reg;
    logic [mrc_pkg::PROD_W-1:0] total_reg;

    logic [EW-1:0] e_sub;
    logic [EW-1:0] e_ss;
    logic [EW-1:0] e_vp;
    logic [EW-1:0] e_cam;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            super_sample_reg <= EW'(1);
            sub_sample_reg   <= EW'(1);
            viewport_reg     <= EW'(1);
            sub_camera_reg   <= EW'(1);
        end
        else if (cfg_write)
        begin
            unique case (mrc_pkg::cfg_reg_t'(cfg_index))
                mrc_pkg::REG_SUPER_SAMPLE: super_sample_reg <= cfg_data;
                mrc_pkg::REG_SUB_SAMPLE:   sub_sample_reg   <= cfg_data;
                mrc_pkg::REG_VIEWPORT:     viewport_reg     <= cfg_data;
                mrc_pkg::REG_SUB_CAMERA:   sub_camera_reg   <= cfg_data;
                default:                   super_sample_reg <= super_sample_reg;
            endcase
        end
    end

    assign e_sub = mrc_pkg::eff_extent(sub_sample_reg, EXT_CAP);
    assign e_ss  = mrc_pkg::eff_extent(super_sample_reg, EXT_CAP);
    assign e_vp  = mrc_pkg::eff_extent(viewport_reg, EXT_CAP);
    assign e_cam = mrc_pkg::eff_extent(sub_camera_reg, EXT_CAP);

    // One multiplier per stage; after a write, w1, w2 and total settle in turn.
    always_ff @(posedge clk)
    begin
        w1_reg    <= mrc_pkg::W1_W'(e_sub) * mrc_pkg::W1_W'(e_ss);
        w2_reg    <= mrc_pkg::W2_W'(w1_reg) * mrc_pkg::W2_W'(e_vp);
        total_reg <= mrc_pkg::PROD_W'(w2_reg) * mrc_pkg::PROD_W'(e_cam);
    end

    always_comb
    begin
        ext.sub_sample   = e_sub;
        ext.super_sample = e_ss;
        ext.viewport     = e_vp;
        ext.sub_camera   = e_cam;
        ext.w1           = w1_reg;
        ext.w2           = w2_reg;
        ext.total        = total_reg;
    end

endmodule

>>> hdl/mrc_cell.sv
// ============================================================================
// mrc_cell: one step of the restoring divider chain
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and passes the record on to its neighbor.
// ============================================================================
module mrc_cell #(
    parameter int DIGIT = 0,
    parameter bit FIRST = 1'b0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mrc_pkg::EXT_W-1:0]    divisor,
    input  logic                         in_valid,
    input  mrc_pkg::stage_t              in_data,
    output logic                         out_valid,
    output mrc_pkg::stage_t              out_data
);

    localparam int EW   = mrc_pkg::EXT_W;
    localparam int LW   = mrc_pkg::LIN_W;
    localparam int SLOT = (DIGIT > 0) ? DIGIT - 1 : 0;

    logic            valid_reg;
    mrc_pkg::stage_t data_reg;
    mrc_pkg::stage_t data_next;

    logic [EW-1:0] rem_base;
    logic [EW:0]   shifted;
    logic [EW:0]   diff;
    logic          fits;

    always_comb
    begin
        rem_base  = FIRST ? '0 : in_data.rem;
        shifted   = {rem_base, in_data.quo[LW-1]};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        data_next = in_data;
        data_next.quo = {in_data.quo[LW-2:0], fits};
        data_next.rem = fits ? diff[EW-1:0] : shifted[EW-1:0];
        // A new digit starts here: keep the remainder of the one before.
        if (FIRST && (DIGIT > 0))
        begin
            data_next.digit[SLOT] = in_data.rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/mixed_radix_index_converter_core.sv
// ============================================================================
// mixed_radix_index_converter_core: four-digit mixed-radix index converter
// Packs four index components into one linear index, or splits a linear
// index into its components, using four configured digit extents.
// ============================================================================
//
//  Channel         Handshake               Ports
//  --------------  ----------------------  ----------------------------------
//  command         start high, busy low    mode, *_in, linear_in
//  result          done (one-cycle pulse)  linear_out, *_out, total_count,
//                                          in_range
//  configuration   cfg_write               cfg_index, cfg_data
//
//  Each command transaction produces exactly one result transaction; a new
//  command is taken in every cycle while busy is low. A command passes the
//  input register, the divider chain (48 cells, one quotient bit each, for
//  the three divided digits), the product register and the output register.
//  The receiver cannot stall, so nothing ever holds the pipeline back.
//  busy is high during reset, is cleared by the clock once reset is released, then stays low.
//  rst_n clears all valid bits at once; configuration returns to extent one.
//
module mixed_radix_index_converter_core #(
    parameter int MAX_EXTENT   = 16,
    parameter int LINEAR_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [mrc_pkg::COMP_W-1:0]          super_sample_in,
    input  logic [mrc_pkg::COMP_W-1:0]          sub_sample_in,
    input  logic [mrc_pkg::COMP_W-1:0]          viewport_in,
    input  logic [mrc_pkg::COMP_W-1:0]          sub_camera_in,
    input  logic [mrc_pkg::LIN_W-1:0]           linear_in,
    input  logic                                cfg_write,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mrc_pkg::EXT_W-1:0]           cfg_data,
    output logic                                done,
    output logic [mrc_pkg::LIN_W-1:0]           linear_out,
    output logic [mrc_pkg::COMP_W-1:0]          super_sample_out,
    output logic [mrc_pkg::COMP_W-1:0]          sub_sample_out,
    output logic [mrc_pkg::COMP_W-1:0]          viewport_out,
    output logic [mrc_pkg::CAM_W-1:0]           sub_camera_out,
    output logic [mrc_pkg::TOTAL_W-1:0]         total_count,
    output logic                                in_range
);

    localparam int LW  = mrc_pkg::LIN_W;
    localparam int CW  = mrc_pkg::COMP_W;
    localparam int EW  = mrc_pkg::EXT_W;
    localparam int PW  = mrc_pkg::PROD_W;
    localparam int NC  = mrc_pkg::CHAIN_LEN;
    localparam int MASK_BITS = (LINEAR_WIDTH < LW) ? LINEAR_WIDTH : LW;
    // Linear indices wrap to LINEAR_WIDTH bits (never wider than the port).
    localparam logic [LW-1:0] LIN_MASK = {LW{1'b1}} >> (LW - MASK_BITS);

    mrc_pkg::extents_t ext;

    logic                          busy_reg;
    logic                          accept;

    // Chain of records: entry 0 is the input register, entry k+1 the
    // output of cell k.
    logic                          chain_valid [NC+1];
    mrc_pkg::stage_t               chain_data  [NC+1];
    logic                          in_valid_reg;
    mrc_pkg::stage_t               in_data_reg;
    mrc_pkg::stage_t               in_data_next;

    // Divisor of each divided digit, least significant first.
    logic [mrc_pkg::NUM_DIV-1:0][EW-1:0] div_sel;

    mrc_pkg::stage_t               last;
    logic [PW-1:0]                 prod_cam_full;
    logic [PW-1:0]                 prod_vp_full;
    logic [PW-1:0]                 prod_ss_full;
    logic                          range_next;

    // Product stage registers.
    logic                          p_valid_reg;
    logic                          p_mode_reg;
    logic [LW-1:0]                 p_cam_reg;
    logic [LW-1:0]                 p_vp_reg;
    logic [LW-1:0]                 p_ss_reg;
    logic [LW-1:0]                 p_sub_reg;
    logic [CW-1:0]                 p_sub_out_reg;
    logic [CW-1:0]                 p_ss_out_reg;
    logic [CW-1:0]                 p_vp_out_reg;
    logic [LW-1:0]                 p_cam_out_reg;
    logic                          p_range_reg;

    // Output registers.
    logic                          done_reg;
    logic [LW-1:0]                 linear_out_reg;
    logic [LW-1:0]                 linear_out_next;
    logic [CW-1:0]                 super_sample_out_reg;
    logic [CW-1:0]                 sub_sample_out_reg;
    logic [CW-1:0]                 viewport_out_reg;
    logic [mrc_pkg::CAM_W-1:0]     sub_camera_out_reg;
    logic [mrc_pkg::TOTAL_W-1:0]   total_count_reg;
    logic                          in_range_reg;

    mrc_extents #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_extents (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ext       (ext)
    );

    // The block only holds off commands while coming out of reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    // Input register. The dividend starts out as the (wrapped) linear index.
    always_comb
    begin
        in_data_next              = '0;
        in_data_next.mode         = mode;
        in_data_next.lin          = linear_in & LIN_MASK;
        in_data_next.quo          = linear_in & LIN_MASK;
        in_data_next.super_sample = super_sample_in;
        in_data_next.sub_sample   = sub_sample_in;
        in_data_next.viewport     = viewport_in;
        in_data_next.sub_camera   = sub_camera_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    // Sub sample is divided off first, then super sample, then viewport;
    // the quotient left over is the sub camera digit.
    assign div_sel = {ext.viewport, ext.super_sample, ext.sub_sample};

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        mrc_cell #(
            .DIGIT (k / LW),
            .FIRST ((k % LW) == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (div_sel[k / LW]),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    assign last = chain_data[NC];

    // Pack mode uses the place weights: by the time a record leaves the
    // chain, the weight registers have long settled after the last write.
    always_comb
    begin
        prod_cam_full = PW'(last.sub_camera) * PW'(ext.w2);
        prod_vp_full  = PW'(last.viewport) * PW'(ext.w1);
        prod_ss_full  = PW'(last.super_sample) * PW'(ext.sub_sample);
        if (last.mode)
        begin
            range_next = {{(PW-LW){1'b0}}, last.lin} < ext.total;
        end
        else
        begin
            range_next = ({1'b0, last.super_sample} < ext.super_sample)
                      && ({1'b0, last.sub_sample} < ext.sub_sample)
                      && ({1'b0, last.viewport} < ext.viewport)
                      && ({1'b0, last.sub_camera} < ext.sub_camera);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= chain_valid[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        p_mode_reg    <= last.mode;
        p_cam_reg     <= prod_cam_full[LW-1:0];
        p_vp_reg      <= prod_vp_full[LW-1:0];
        p_ss_reg      <= prod_ss_full[LW-1:0];
        p_sub_reg     <= LW'(last.sub_sample);
        p_sub_out_reg <= last.digit[0][CW-1:0];
        p_ss_out_reg  <= last.digit[1][CW-1:0];
        p_vp_out_reg  <= last.rem[CW-1:0];
        p_cam_out_reg <= last.quo;
        p_range_reg   <= range_next;
    end

    // The packed sum wraps at the port width and is then masked.
    assign linear_out_next = (p_cam_reg + p_vp_reg + p_ss_reg + p_sub_reg) & LIN_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p_valid_reg;
        end
    end

    // Fields that do not belong to the transaction's mode read as zero.
    always_ff @(posedge clk)
    begin
        linear_out_reg       <= p_mode_reg ? '0 : linear_out_next;
        super_sample_out_reg <= p_mode_reg ? p_ss_out_reg : '0;
        sub_sample_out_reg   <= p_mode_reg ? p_sub_out_reg : '0;
        viewport_out_reg     <= p_mode_reg ? p_vp_out_reg : '0;
        sub_camera_out_reg   <= p_mode_reg ? p_cam_out_reg : '0;
        total_count_reg      <= ext.total[mrc_pkg::TOTAL_W-1:0];
        in_range_reg         <= p_range_reg;
    end

    assign done             = done_reg;
    assign linear_out       = linear_out_reg;
    assign super_sample_out = super_sample_out_reg;
    assign sub_sample_out   = sub_sample_out_reg;
    assign viewport_out     = viewport_out_reg;
    assign sub_camera_out   = sub_camera_out_reg;
    assign total_count      = total_count_reg;
    assign in_range         = in_range_reg;

endmodule

>>> hdl/mrc_checker.sv
// ============================================================================
// mrc_checker: port-level checks of the index converter
// Watches the command and result ports for the fixed latency and for the
// fields that must read zero in each mode.
// ============================================================================
module mrc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                mode,
    input  logic                                done,
    input  logic [mrc_pkg::LIN_W-1:0]           linear_out,
    input  logic [mrc_pkg::COMP_W-1:0]          super_sample_out,
    input  logic [mrc_pkg::COMP_W-1:0]          sub_sample_out,
    input  logic [mrc_pkg::COMP_W-1:0]          viewport_out,
    input  logic [mrc_pkg::CAM_W-1:0]           sub_camera_out,
    input  logic [mrc_pkg::TOTAL_W-1:0]         total_count
);

    localparam int LAT = mrc_pkg::PIPE_LAT;

    // Every accepted command yields its result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after an accepted command");

    // No result appears without a command accepted the same latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching command");

    // A split transaction leaves the packed index at zero.
    a_split_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, LAT)) |-> (linear_out == '0))
        else $error("linear_out not zero for a split transaction");

    // A pack transaction leaves every split component at zero.
    a_pack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(mode, LAT)) |->
        (super_sample_out == '0 && sub_sample_out == '0
         && viewport_out == '0 && sub_camera_out == '0))
        else $error("split components not zero for a pack transaction");

    // The product of extents, each at least one, never reads zero.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (total_count != '0))
        else $error("total_count reads zero");

endmodule

bind mixed_radix_index_converter_core mrc_checker u_mrc_checker (.*);

>>> verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for mixed_radix_index_converter_core
// Drives pack and split commands under many extent settings and checks each
// result against a behavioral index converter or a hand-written one. A
// directed table covers the extremes first. Random phases follow, each with
// fresh extents and random sender gaps (none in bursts); one drains mid-phase.
// ============================================================================
module tb;

    localparam int COMP_W         = mrc_pkg::COMP_W;
    localparam int LIN_W          = mrc_pkg::LIN_W;
    localparam int CAM_W          = mrc_pkg::CAM_W;
    localparam int TOTAL_W        = mrc_pkg::TOTAL_W;
    localparam int EXT_W          = mrc_pkg::EXT_W;
    localparam int CFG_IDX_W      = mrc_pkg::CFG_IDX_W;

    localparam int MAX_EXTENT     = 16;
    localparam int LINEAR_WIDTH   = 16;
    // Cycles without any accepted command or returned result before the run is declared hung.
    // This covers the longest sender gap, a full drain and an extent update.
    localparam int STALL_LIMIT    = 1000;
    localparam int RANDOM_PHASES  = 14;
    localparam int ITEMS_PER_PHASE = 100;

    typedef enum logic {
        MODE_PACK  = 1'b0,
        MODE_SPLIT = 1'b1
    } mode_t;

    // One command transaction as it appears on the input ports.
    typedef struct packed {
        mode_t              mode;
        logic [COMP_W-1:0]  ss;
        logic [COMP_W-1:0]  sub;
        logic [COMP_W-1:0]  vp;
        logic [COMP_W-1:0]  cam;
        logic [LIN_W-1:0]   lin;
    } cmd_t;

    // One result transaction as it appears on the output ports.
    typedef struct packed {
        logic [LIN_W-1:0]   lin;
        logic [COMP_W-1:0]  ss;
        logic [COMP_W-1:0]  sub;
        logic [COMP_W-1:0]  vp;
        logic [CAM_W-1:0]   cam;
        logic [TOTAL_W-1:0] total;
        logic               ok;
    } result_t;

    // A row of the directed table either reloads the four extents or issues
    // one command, optionally with a hand-written expected result.
    typedef struct {
        bit                 reload;
        logic [EXT_W-1:0]   ext_ss;
        logic [EXT_W-1:0]   ext_sub;
        logic [EXT_W-1:0]   ext_vp;
        logic [EXT_W-1:0]   ext_cam;
        cmd_t               cmd;
        bit                 literal;
        result_t            want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 mode = 1'b0;
    logic [COMP_W-1:0]    super_sample_in = '0;
    logic [COMP_W-1:0]    sub_sample_in = '0;
    logic [COMP_W-1:0]    viewport_in = '0;
    logic [COMP_W-1:0]    sub_camera_in = '0;
    logic [LIN_W-1:0]     linear_in = '0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [EXT_W-1:0]     cfg_data = '0;
    logic                 done;
    logic [LIN_W-1:0]     linear_out;
    logic [COMP_W-1:0]    super_sample_out;
    logic [COMP_W-1:0]    sub_sample_out;
    logic [COMP_W-1:0]    viewport_out;
    logic [CAM_W-1:0]     sub_camera_out;
    logic [TOTAL_W-1:0]   total_count;
    logic                 in_range;

    // Bench copy of the extent registers, indexed by register code.
    logic [EXT_W-1:0]     extent_reg [4] = '{default: EXT_W'(1)};

    // Expected results in the order their commands were accepted.
    result_t              pending_results [$];

    int                   error_count = 0;
    int                   results_checked = 0;
    int                   in_range_seen = 0;
    int                   pack_items = 0;
    int                   split_items = 0;
    int                   settings_loaded = 0;
    int                   stall_cycles = 0;

    mixed_radix_index_converter_core #(
        .MAX_EXTENT   (MAX_EXTENT),
        .LINEAR_WIDTH (LINEAR_WIDTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .super_sample_in  (super_sample_in),
        .sub_sample_in    (sub_sample_in),
        .viewport_in      (viewport_in),
        .sub_camera_in    (sub_camera_in),
        .linear_in        (linear_in),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .linear_out       (linear_out),
        .super_sample_out (super_sample_out),
        .sub_sample_out   (sub_sample_out),
        .viewport_out     (viewport_out),
        .sub_camera_out   (sub_camera_out),
        .total_count      (total_count),
        .in_range         (in_range)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // A register value of zero acts as an extent of one, and anything above
    // the cap acts as the cap.
    function automatic int extent_of(logic [EXT_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_EXTENT)
        begin
            return MAX_EXTENT;
        end
        return int'(v);
    endfunction

    // Behavioral converter: the result a command must produce under the
    // extents currently held in the bench copy of the registers.
    function automatic result_t convert_index(cmd_t c);
        int      e_ss;
        int      e_sub;
        int      e_vp;
        int      e_cam;
        int      total;
        int      lin;
        longint  packed_v;
        result_t r;
        e_ss  = extent_of(extent_reg[mrc_pkg::REG_SUPER_SAMPLE]);
        e_sub = extent_of(extent_reg[mrc_pkg::REG_SUB_SAMPLE]);
        e_vp  = extent_of(extent_reg[mrc_pkg::REG_VIEWPORT]);
        e_cam = extent_of(extent_reg[mrc_pkg::REG_SUB_CAMERA]);
        total = e_ss * e_sub * e_vp * e_cam;
        r = '0;
        r.total = total[TOTAL_W-1:0];
        if (c.mode == MODE_PACK)
        begin
            // The sub camera digit is most significant, sub sample least.
            packed_v = ((longint'(c.cam) * e_vp + c.vp) * e_ss + c.ss) * e_sub + c.sub;
            r.lin = packed_v[LIN_W-1:0];
            r.ok  = (int'(c.ss) < e_ss) && (int'(c.sub) < e_sub)
                 && (int'(c.vp) < e_vp) && (int'(c.cam) < e_cam);
        end
        else
        begin
            // The top digit keeps the whole remaining quotient.
            lin   = int'(c.lin);
            r.sub = COMP_W'(lin % e_sub);
            r.ss  = COMP_W'((lin / e_sub) % e_ss);
            r.vp  = COMP_W'((lin / (e_sub * e_ss)) % e_vp);
            r.cam = CAM_W'(lin / (e_sub * e_ss * e_vp));
            r.ok  = lin < total;
        end
        return r;
    endfunction

    function automatic cmd_t pack_cmd(int ss, int sub, int vp, int cam);
        cmd_t c;
        c      = '0;
        c.mode = MODE_PACK;
        c.ss   = COMP_W'(ss);
        c.sub  = COMP_W'(sub);
        c.vp   = COMP_W'(vp);
        c.cam  = COMP_W'(cam);
        return c;
    endfunction

    function automatic cmd_t split_cmd(int lin);
        cmd_t c;
        c      = '0;
        c.mode = MODE_SPLIT;
        c.lin  = LIN_W'(lin);
        return c;
    endfunction

    function automatic result_t known_result(int lin, int ss, int sub, int vp,
                                             int cam, int total, bit ok);
        result_t r;
        r.lin   = LIN_W'(lin);
        r.ss    = COMP_W'(ss);
        r.sub   = COMP_W'(sub);
        r.vp    = COMP_W'(vp);
        r.cam   = CAM_W'(cam);
        r.total = TOTAL_W'(total);
        r.ok    = ok;
        return r;
    endfunction

    function automatic row_t reload_row(int ss, int sub, int vp, int cam);
        row_t row;
        row         = '{default: '0};
        row.reload  = 1'b1;
        row.ext_ss  = EXT_W'(ss);
        row.ext_sub = EXT_W'(sub);
        row.ext_vp  = EXT_W'(vp);
        row.ext_cam = EXT_W'(cam);
        return row;
    endfunction

    function automatic row_t item_row(cmd_t c);
        row_t row;
        row     = '{default: '0};
        row.cmd = c;
        return row;
    endfunction

    function automatic row_t checked_row(cmd_t c, result_t want);
        row_t row;
        row         = item_row(c);
        row.literal = 1'b1;
        row.want    = want;
        return row;
    endfunction

    // Mostly legal extents, with some zero and some oversized register values.
    function automatic logic [EXT_W-1:0] random_extent();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return EXT_W'($urandom_range(MAX_EXTENT + 1, 31));
        end
        return EXT_W'($urandom_range(1, MAX_EXTENT));
    endfunction

    // Sender gap after a transaction: mostly none or short, a few long.
    function automatic int random_gap(bit burst);
        int pick;
        if (burst)
        begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Presents a command at the current rising edge and holds it until the
    // block takes it. busy is sampled at the falling edge, where it is
    // stable, so the following rising edge is the acceptance edge.
    task automatic issue_command(cmd_t c, bit use_literal, result_t literal);
        start           <= 1'b1;
        mode            <= c.mode;
        super_sample_in <= c.ss;
        sub_sample_in   <= c.sub;
        viewport_in     <= c.vp;
        sub_camera_in   <= c.cam;
        linear_in       <= c.lin;
        do
        begin
            @(negedge clk);
        end
        while (busy);
        @(posedge clk);
        pending_results.push_back(use_literal ? literal : convert_index(c));
        if (c.mode == MODE_PACK)
        begin
            pack_items++;
        end
        else
        begin
            split_items++;
        end
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic wait_pipeline_empty();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Drives the write of one register; the caller lowers the write enable.
    task automatic write_reg(mrc_pkg::cfg_reg_t idx, logic [EXT_W-1:0] value);
        cfg_write       <= 1'b1;
        cfg_index       <= idx;
        cfg_data        <= value;
        extent_reg[idx] = value;
        @(posedge clk);
    endtask

    // Writes all four extents back to back while the block is idle.
    task automatic load_extents(logic [EXT_W-1:0] v_ss, logic [EXT_W-1:0] v_sub,
                                logic [EXT_W-1:0] v_vp, logic [EXT_W-1:0] v_cam);
        write_reg(mrc_pkg::REG_SUPER_SAMPLE, v_ss);
        write_reg(mrc_pkg::REG_SUB_SAMPLE, v_sub);
        write_reg(mrc_pkg::REG_VIEWPORT, v_vp);
        write_reg(mrc_pkg::REG_SUB_CAMERA, v_cam);
        cfg_write <= 1'b0;
        settings_loaded++;
        repeat (2) @(posedge clk);
    endtask

    // Every done pulse is one result transaction; outputs are sampled at the
    // edge that ends the pulse, before the block updates them.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no command outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("linear_out", want.lin, linear_out);
                check_field("super_sample_out", want.ss, super_sample_out);
                check_field("sub_sample_out", want.sub, sub_sample_out);
                check_field("viewport_out", want.vp, viewport_out);
                check_field("sub_camera_out", want.cam, sub_camera_out);
                check_field("total_count", want.total, total_count);
                check_field("in_range", want.ok, in_range);
                results_checked++;
                if (in_range)
                begin
                    in_range_seen++;
                end
            end
        end
    end

    // Ends the run if neither side moves a transaction for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("mixed_radix_index_converter_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        row_t    rows [$];
        cmd_t    c;
        result_t none;
        int      total;
        bit      burst;

        none = '0;

        // Directed table. Under reset extents of one every component but
        // zero is out of range and a split leaves everything in the top digit.
        rows.push_back(checked_row(pack_cmd(0, 0, 0, 0), known_result(0, 0, 0, 0, 0, 1, 1)));
        rows.push_back(checked_row(pack_cmd(15, 15, 15, 15),
                                   known_result(60, 0, 0, 0, 0, 1, 0)));
        rows.push_back(checked_row(split_cmd(0), known_result(0, 0, 0, 0, 0, 1, 1)));
        rows.push_back(checked_row(split_cmd(65535), known_result(0, 0, 0, 0, 65535, 1, 0)));
        // Largest extents: the whole 16-bit space is in range.
        rows.push_back(reload_row(16, 16, 16, 16));
        rows.push_back(checked_row(pack_cmd(15, 15, 15, 15),
                                   known_result(65535, 0, 0, 0, 0, 65536, 1)));
        rows.push_back(checked_row(split_cmd(65535),
                                   known_result(0, 15, 15, 15, 15, 65536, 1)));
        rows.push_back(checked_row(pack_cmd(0, 0, 0, 0), known_result(0, 0, 0, 0, 0, 65536, 1)));
        rows.push_back(checked_row(split_cmd(0), known_result(0, 0, 0, 0, 0, 65536, 1)));
        // Zero register values behave as extents of one.
        rows.push_back(reload_row(0, 0, 0, 0));
        rows.push_back(item_row(pack_cmd(1, 0, 0, 0)));
        rows.push_back(item_row(split_cmd(5)));
        // Oversized register values behave as the cap.
        rows.push_back(reload_row(31, 31, 31, 31));
        rows.push_back(item_row(split_cmd(12345)));
        rows.push_back(item_row(pack_cmd(3, 7, 9, 2)));
        // Uneven extents: the edges of the range on both sides.
        rows.push_back(reload_row(3, 5, 7, 2));
        rows.push_back(item_row(split_cmd(209)));
        rows.push_back(item_row(split_cmd(210)));
        rows.push_back(item_row(pack_cmd(2, 4, 6, 1)));
        rows.push_back(item_row(pack_cmd(0, 0, 0, 2)));
        rows.push_back(item_row(pack_cmd(0, 5, 0, 0)));
        // Mixed zero, unit, cap and just-over-cap registers.
        rows.push_back(reload_row(17, 1, 0, 16));
        rows.push_back(item_row(split_cmd(40000)));
        rows.push_back(item_row(pack_cmd(15, 0, 0, 15)));
        rows.push_back(item_row(pack_cmd(0, 0, 1, 0)));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].reload)
            begin
                wait_pipeline_empty();
                load_extents(rows[i].ext_ss, rows[i].ext_sub, rows[i].ext_vp, rows[i].ext_cam);
            end
            else
            begin
                issue_command(rows[i].cmd, rows[i].literal, rows[i].want);
                idle_sender(random_gap(1'b0));
            end
        end

        // Random phases. Each one drains the pipeline, loads a new setting
        // and then streams commands, some phases back to back.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_pipeline_empty();
            load_extents(random_extent(), random_extent(), random_extent(), random_extent());
            total = extent_of(extent_reg[mrc_pkg::REG_SUPER_SAMPLE])
                  * extent_of(extent_reg[mrc_pkg::REG_SUB_SAMPLE])
                  * extent_of(extent_reg[mrc_pkg::REG_VIEWPORT])
                  * extent_of(extent_reg[mrc_pkg::REG_SUB_CAMERA]);
            burst = (phase % 4 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                c.mode = mode_t'($urandom_range(0, 1));
                c.ss   = COMP_W'($urandom_range(0, 15));
                c.sub  = COMP_W'($urandom_range(0, 15));
                c.vp   = COMP_W'($urandom_range(0, 15));
                c.cam  = COMP_W'($urandom_range(0, 15));
                c.lin  = LIN_W'($urandom);
                // Most commands stay inside the current extents so that the
                // interesting digit arithmetic is exercised; the rest are raw.
                if ($urandom_range(0, 3) != 0)
                begin
                    if (c.mode == MODE_PACK)
                    begin
                        c.ss  = COMP_W'($urandom_range(0,
                                    extent_of(extent_reg[mrc_pkg::REG_SUPER_SAMPLE]) - 1));
                        c.sub = COMP_W'($urandom_range(0,
                                    extent_of(extent_reg[mrc_pkg::REG_SUB_SAMPLE]) - 1));
                        c.vp  = COMP_W'($urandom_range(0,
                                    extent_of(extent_reg[mrc_pkg::REG_VIEWPORT]) - 1));
                        c.cam = COMP_W'($urandom_range(0,
                                    extent_of(extent_reg[mrc_pkg::REG_SUB_CAMERA]) - 1));
                    end
                    else
                    begin
                        c.lin = LIN_W'($urandom_range(0, total - 1));
                    end
                end
                issue_command(c, 1'b0, none);
                idle_sender(random_gap(burst));
                // One extra drain in the middle of a phase.
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                begin
                    wait_pipeline_empty();
                end
            end
        end

        wait_pipeline_empty();
        repeat (mrc_pkg::PIPE_LAT + 8) @(posedge clk);

        $display("Coverage: %0d pack and %0d split commands across %0d extent settings.",
                 pack_items, split_items, settings_loaded);
        $display("Checked %0d results, %0d of them flagged in range.",
                 results_checked, in_range_seen);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("mixed_radix_index_converter_core verification clean");
        end
        else
        begin
            $display("mixed_radix_index_converter_core verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/mrc_pkg.sv
hdl/mrc_extents.sv
hdl/mrc_cell.sv
hdl/mixed_radix_index_converter_core.sv
hdl/mrc_checker.sv
verif/tb.sv
